### hw/rtl/imm_pkg.sv
// Shared types and constants for the integer matrix multiply block.
package imm_pkg;

    // Default largest matrix dimension
    localparam int MAX_DIM_DEF = 8;

    // Field widths fixed by the interface
    localparam int IDX_W   = 3;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int RESULT_W = 40;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Request action codes
    localparam logic [1:0] ACT_WRITE_A = 2'd0;
    localparam logic [1:0] ACT_WRITE_B = 2'd1;
    localparam logic [1:0] ACT_RUN     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARED_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

    // One incoming request
    typedef struct packed {
        logic [1:0]              action;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [ELEM_W-1:0] element_value;
    } imm_req_t;

    // One product element
    typedef struct packed {
        logic [IDX_W-1:0]           out_row;
        logic [IDX_W-1:0]           out_col;
        logic signed [RESULT_W-1:0] product_value;
        logic                       last_flag;
    } imm_result_t;

endpackage

### hw/rtl/imm_store.sv
// Element storage for matrices A and B: one write port, registered reads.
module imm_store
    import imm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int DEPTH  = MAX_DIM * MAX_DIM,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  imm_req_t                 wr_req,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_a_addr,
    input  logic [ADDR_W-1:0]        rd_b_addr,
    output logic signed [ELEM_W-1:0] rd_a_data,
    output logic signed [ELEM_W-1:0] rd_b_data
);

    localparam int RAW_W = 2 * IDX_W;

    logic [ELEM_W-1:0] mem_a [DEPTH];
    logic [ELEM_W-1:0] mem_b [DEPTH];

    logic              in_range;
    logic [RAW_W-1:0]  wr_raw;
    logic [ADDR_W-1:0] wr_addr;
    logic              we_a;
    logic              we_b;

    // Address decode; writes outside the store are dropped
    assign in_range = ({1'b0, wr_req.row_index} < (IDX_W+1)'(MAX_DIM)) &&
                      ({1'b0, wr_req.col_index} < (IDX_W+1)'(MAX_DIM));
    assign wr_raw   = RAW_W'(wr_req.row_index) * RAW_W'(MAX_DIM) +
                      RAW_W'(wr_req.col_index);
    assign wr_addr  = wr_raw[ADDR_W-1:0];

    always_comb
    begin
        we_a = 1'b0;
        we_b = 1'b0;
        case (wr_req.action)
            ACT_WRITE_A: we_a = wr_en && in_range;
            ACT_WRITE_B: we_b = wr_en && in_range;
            default:
            begin
                we_a = 1'b0;
                we_b = 1'b0;
            end
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_addr] <= wr_req.element_value;
        end
        if (we_b)
        begin
            mem_b[wr_addr] <= wr_req.element_value;
        end
        if (rd_en)
        begin
            rd_a_data <= mem_a[rd_a_addr];
            rd_b_data <= mem_b[rd_b_addr];
        end
    end

endmodule

### hw/rtl/integer_matrix_multiply.sv
// Signed integer matrix multiply: element loads, then a run emits A x B row-major.
// A load request leaves busy low, so the next request may follow at once.
// During a run busy is high; each dimension is capped at MAX_DIM.
// Each term is a memory read, one 16x16 multiply and one 40-bit accumulate through the
// single shared MAC; each element shows for one cycle on done; the receiver cannot stall it.
// Reset (rst_n, async low) sets all dimensions to 1; element stores are undefined until written.
module integer_matrix_multiply
    import imm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  imm_req_t             request,
    output logic                 done,
    output imm_result_t          result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] rows_a_reg, shared_dim_reg, cols_b_reg;
    logic [CNT_W-1:0] nr_reg, nk_reg, nc_reg;
    logic [CNT_W-1:0] nr_next, nk_next, nc_next;
    logic [DIM_W-1:0] r_reg, c_reg, k_reg;
    logic [DIM_W-1:0] r_next, c_next, k_next;

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [RESULT_W-1:0] acc_reg;
    logic signed [ELEM_W-1:0]   a_data, b_data;

    logic              accept;
    logic              load_req;
    logic              run_req;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
    logic              k_last, c_last, r_last;
    logic              acc_clear;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [CNT_W-1:0] v;
        if (d > CFG_W'(MAX_DIM))
        begin
            v = CNT_W'(MAX_DIM);
        end
        else
        begin
            v = d[CNT_W-1:0];
        end
        return v;
    endfunction

    // Request decode
    assign accept   = start && !busy;
    assign load_req = accept && (request.action == ACT_WRITE_A ||
                                 request.action == ACT_WRITE_B);
    assign run_req  = accept && (request.action == ACT_RUN);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg     <= CFG_W'(1);
            shared_dim_reg <= CFG_W'(1);
            cols_b_reg     <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_A:     rows_a_reg     <= cfg_data;
                REG_SHARED_DIM: shared_dim_reg <= cfg_data;
                REG_COLS_B:     cols_b_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Element stores
    imm_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk       (clk),
        .wr_en     (load_req),
        .wr_req    (request),
        .rd_en     (rd_en),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (a_data),
        .rd_b_data (b_data)
    );

    // A[r][k] and B[k][c]
    assign rd_en     = (state_reg == ST_READ);
    assign rd_a_addr = ADDR_W'(r_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
    assign rd_b_addr = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(c_reg);

    // Loop end flags
    assign k_last = (CNT_W'(k_reg) + CNT_W'(1)) == nk_reg;
    assign c_last = (CNT_W'(c_reg) + CNT_W'(1)) == nc_reg;
    assign r_last = (CNT_W'(r_reg) + CNT_W'(1)) == nr_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        nr_next    = nr_reg;
        nk_next    = nk_reg;
        nc_next    = nc_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        acc_clear  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (run_req)
                begin
                    nr_next   = clamp_dim(rows_a_reg);
                    nk_next   = clamp_dim(shared_dim_reg);
                    nc_next   = clamp_dim(cols_b_reg);
                    r_next    = '0;
                    c_next    = '0;
                    k_next    = '0;
                    acc_clear = 1'b1;
                    if (nr_next == '0 || nc_next == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (nk_next == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (k_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next     = k_reg + DIM_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                k_next    = '0;
                acc_clear = 1'b1;
                if (c_last)
                begin
                    c_next = '0;
                    r_next = r_reg + DIM_W'(1);
                end
                else
                begin
                    c_next = c_reg + DIM_W'(1);
                end
                if (c_last && r_last)
                begin
                    state_next = ST_IDLE;
                end
                else if (nk_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nr_reg    <= '0;
            nk_reg    <= '0;
            nc_reg    <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nr_reg    <= nr_next;
            nk_reg    <= nk_next;
            nc_reg    <= nc_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    // Shared multiply-accumulate
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= a_data * b_data;
        end
        if (acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == ST_ACC)
        begin
            acc_reg <= acc_reg + {{(RESULT_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // Outputs
    assign busy                 = (state_reg != ST_IDLE);
    assign done                 = (state_reg == ST_EMIT);
    assign result.out_row       = IDX_W'(r_reg);
    assign result.out_col       = IDX_W'(c_reg);
    assign result.product_value = acc_reg;
    assign result.last_flag     = c_last && r_last;

    // Checks
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.last_flag |=> !busy)
        else $error("run did not end after last element");

    a_more_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last_flag |=> busy)
        else $error("run ended before last element");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (CNT_W'(r_reg) < nr_reg) && (CNT_W'(c_reg) < nc_reg))
        else $error("product index outside dimensions");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_req |=> !busy && !done)
        else $error("load request started a run");

endmodule

### test/integer_matrix_multiply_tb.sv
// Self-checking testbench for the integer matrix multiply block.
module integer_matrix_multiply_tb;
    import imm_pkg::*;

    localparam int MAX_DIM       = MAX_DIM_DEF;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int SCRIPT_LEN    = 27;
    localparam int PRINT_CAP     = 100;

    // Action code with no meaning to the block, and the unmapped register index
    localparam logic [1:0]           ACT_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    // One row of the directed script: a register write or a request
    typedef struct packed {
        bit                         is_cfg;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [CFG_W-1:0]           reg_val;
        imm_req_t                   req;
        bit                         typed;
        logic signed [RESULT_W-1:0] typed_value;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    imm_req_t             request = '0;
    logic                 done;
    imm_result_t          result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Shadow of the block: element stores, written flags, dimensions
    logic signed [ELEM_W-1:0] shadow_a [STORE_DEPTH];
    logic signed [ELEM_W-1:0] shadow_b [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]   a_written = '0;
    logic [STORE_DEPTH-1:0]   b_written = '0;
    logic [CFG_W-1:0]         dim_rows = 4'd1;
    logic [CFG_W-1:0]         dim_shared = 4'd1;
    logic [CFG_W-1:0]         dim_cols = 4'd1;

    imm_result_t pending_products [$];
    script_row_t script [SCRIPT_LEN];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sent_count = 0;
    int unsigned sender_idle_pct = 0;

    integer_matrix_multiply #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : d;
    endfunction

    // Apply one request to the shadow; a run queues the whole product row-major
    task automatic compute_products(imm_req_t req);
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        int unsigned count;
        int          slot;
        longint      acc;
        imm_result_t res;
        // row and column fields are 3 bits, so a load always lands in the store
        slot = req.row_index * MAX_DIM + req.col_index;
        case (req.action)
            ACT_WRITE_A:
            begin
                shadow_a[slot] = req.element_value;
                a_written[slot] = 1'b1;
            end
            ACT_WRITE_B:
            begin
                shadow_b[slot] = req.element_value;
                b_written[slot] = 1'b1;
            end
            ACT_RUN:
            begin
                nr = clamp_dim(dim_rows);
                nk = clamp_dim(dim_shared);
                nc = clamp_dim(dim_cols);
                count = 0;
                for (int r = 0; r < nr; r++)
                begin
                    for (int c = 0; c < nc; c++)
                    begin
                        acc = 0;
                        for (int k = 0; k < nk; k++)
                            acc += longint'(shadow_a[r * MAX_DIM + k])
                                 * longint'(shadow_b[k * MAX_DIM + c]);
                        count++;
                        res.out_row = 3'(r);
                        res.out_col = 3'(c);
                        res.product_value = acc[RESULT_W-1:0];
                        res.last_flag = (count == nr * nc);
                        pending_products.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly small dimensions; sometimes zero, the maximum, or above it
    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 12)
            return 4'(MAX_DIM);
        if (roll < 17)
            return 4'($urandom_range(15, MAX_DIM + 1));
        return 4'($urandom_range(3, 1));
    endfunction

    // Sender gaps at the current rate
    task automatic idle_pace();
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold the request until accepted, then update the shadow
    task automatic send_request(imm_req_t req, bit use_model);
        idle_pace();
        start <= 1'b1;
        cfg_we <= 1'b0;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (use_model)
            compute_products(req);
        if (req.action != ACT_IGNORED)
            sent_count++;
    endtask

    // Before a run, load every entry it reads that was never written
    task automatic issue(imm_req_t req, bit use_model);
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        imm_req_t    fill;
        if (req.action == ACT_RUN)
        begin
            nr = clamp_dim(dim_rows);
            nk = clamp_dim(dim_shared);
            nc = clamp_dim(dim_cols);
            if (nr != 0 && nc != 0)
            begin
                for (int k = 0; k < nk; k++)
                begin
                    for (int r = 0; r < nr; r++)
                    begin
                        if (!a_written[r * MAX_DIM + k])
                        begin
                            fill.action = ACT_WRITE_A;
                            fill.row_index = 3'(r);
                            fill.col_index = 3'(k);
                            fill.element_value = pick_value();
                            send_request(fill, 1'b1);
                        end
                    end
                    for (int c = 0; c < nc; c++)
                    begin
                        if (!b_written[k * MAX_DIM + c])
                        begin
                            fill.action = ACT_WRITE_B;
                            fill.row_index = 3'(k);
                            fill.col_index = 3'(c);
                            fill.element_value = pick_value();
                            send_request(fill, 1'b1);
                        end
                    end
                end
            end
        end
        send_request(req, use_model);
    endtask

    // Sender waits until every product is out and the block is idle
    task automatic drain();
        start <= 1'b0;
        cfg_we <= 1'b0;
        @(posedge clk);
        while (pending_products.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_we stays high; the next request or drain lowers it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_ROWS_A:     dim_rows = val;
            REG_SHARED_DIM: dim_shared = val;
            REG_COLS_B:     dim_cols = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_W-1:0] r, logic [CFG_W-1:0] s, logic [CFG_W-1:0] c);
        drain();
        write_reg(REG_ROWS_A, r);
        write_reg(REG_SHARED_DIM, s);
        write_reg(REG_COLS_B, c);
    endtask

    // Random episode: maybe new dimensions, a few loads with some noise, then most often a run
    task automatic random_episode();
        imm_req_t req;
        int       n;
        if ($urandom_range(3) == 0)
            configure(pick_dim(), pick_dim(), pick_dim());
        n = $urandom_range(6);
        repeat (n)
        begin
            req.action = ($urandom_range(1) != 0) ? ACT_WRITE_B : ACT_WRITE_A;
            if ($urandom_range(19) == 0)
                req.action = ACT_IGNORED;
            req.row_index = 3'($urandom);
            req.col_index = 3'($urandom);
            req.element_value = pick_value();
            issue(req, 1'b1);
        end
        if ($urandom_range(9) != 0)
        begin
            req.action = ACT_RUN;
            req.row_index = 3'($urandom);
            req.col_index = 3'($urandom);
            req.element_value = 16'($urandom);
            issue(req, 1'b1);
        end
        if ($urandom_range(15) == 0)
            drain();
    endtask

    function automatic script_row_t ld_row(logic [1:0] act, int r, int c,
                                           logic signed [ELEM_W-1:0] v);
        script_row_t row;
        row = '0;
        row.req.action = act;
        row.req.row_index = 3'(r);
        row.req.col_index = 3'(c);
        row.req.element_value = v;
        return row;
    endfunction

    function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        script_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic script_row_t run_row(bit typed, logic signed [RESULT_W-1:0] value);
        script_row_t row;
        row = '0;
        row.req.action = ACT_RUN;
        row.typed = typed;
        row.typed_value = value;
        return row;
    endfunction

    // Each strobed product against the oldest expectation
    always @(posedge clk)
    begin : check_products
        imm_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_products.size() == 0)
                report_mismatch($sformatf("unexpected product r%0d c%0d = %0d last %0d",
                    result.out_row, result.out_col, result.product_value, result.last_flag));
            else
            begin
                want = pending_products.pop_front();
                if (result.out_row !== want.out_row || result.out_col !== want.out_col
                    || result.product_value !== want.product_value
                    || result.last_flag !== want.last_flag)
                    report_mismatch($sformatf(
                        "got r%0d c%0d = %0d last %0d, expected r%0d c%0d = %0d last %0d",
                        result.out_row, result.out_col, result.product_value,
                        result.last_flag, want.out_row, want.out_col,
                        want.product_value, want.last_flag));
            end
        end
    end

    initial
    begin
        imm_result_t typed_res;
        int          base;

        // 1x1x1 extremes, ignored action, zero dims, saturated dims, unmapped index
        script = '{
            ld_row(ACT_WRITE_A, 0, 0, 16'sh7fff),
            ld_row(ACT_WRITE_B, 0, 0, 16'sh7fff),
            run_row(1'b1, 40'sd1073676289),
            ld_row(ACT_WRITE_A, 0, 0, 16'sh8000),
            run_row(1'b1, -40'sd1073709056),
            ld_row(ACT_WRITE_B, 0, 0, 16'sh8000),
            run_row(1'b1, 40'sd1073741824),
            ld_row(ACT_IGNORED, 7, 7, '1),
            cfg_row(REG_SHARED_DIM, 4'd0),
            run_row(1'b1, 40'sd0),
            cfg_row(REG_ROWS_A, 4'd0),
            run_row(1'b0, '0),
            cfg_row(REG_ROWS_A, 4'd15),
            run_row(1'b0, '0),
            cfg_row(REG_SHARED_DIM, 4'd15),
            cfg_row(REG_COLS_B, 4'd8),
            ld_row(ACT_WRITE_A, 7, 7, 16'sh5a5a),
            ld_row(ACT_WRITE_B, 7, 7, '1),
            run_row(1'b0, '0),
            cfg_row(REG_UNUSED, 4'd0),
            run_row(1'b0, '0),
            cfg_row(REG_COLS_B, 4'd0),
            run_row(1'b0, '0),
            cfg_row(REG_ROWS_A, 4'd1),
            cfg_row(REG_SHARED_DIM, 4'd1),
            cfg_row(REG_COLS_B, 4'd1),
            run_row(1'b1, 40'sd1073741824)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script
        sender_idle_pct = 18;
        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
            begin
                issue(script[i].req, !script[i].typed);
                if (script[i].typed)
                begin
                    typed_res.out_row = '0;
                    typed_res.out_col = '0;
                    typed_res.product_value = script[i].typed_value;
                    typed_res.last_flag = 1'b1;
                    pending_products.push_back(typed_res);
                end
            end
        end

        // Random phases: light sender gaps, heavy gaps, then back to back
        base = sent_count;
        sender_idle_pct = 18;
        while (sent_count < base + 100)
            random_episode();
        drain();
        sender_idle_pct = 64;
        while (sent_count < base + 200)
            random_episode();
        drain();
        sender_idle_pct = 0;
        while (sent_count < base + 300)
            random_episode();

        drain();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
